>>> sv/g4bp_pkg.sv
package g4bp_pkg;

  localparam int PanelWidth  = 256;
  localparam int PanelHeight = 128;
  localparam int RowBytes    = 16;
  localparam int FrameBytes  = 4096;
  localparam int AddrW       = 12;
  localparam int FillW       = 13;

  typedef enum logic [3:0] {
    OP_CLEAR = 4'd0,
    OP_PIXEL = 4'd1,
    OP_HLINE = 4'd2,
    OP_VLINE = 4'd3,
    OP_RECT  = 4'd4,
    OP_FILL  = 4'd5,
    OP_RLEB  = 4'd6,
    OP_RLEE  = 4'd7,
    OP_READ  = 4'd8
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SPAN_SETUP,
    ST_SPAN_RD,
    ST_SPAN_WAIT,
    ST_SPAN_WR,
    ST_RUN,
    ST_READ_WAIT,
    ST_DONE,
    ST_INIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       latch;      // capture the command word
    logic       clr_init;   // reset sweep address
    logic       clr_step;   // write one clear byte, advance
    logic       clr_zero;   // sweep writes zero (after reset)
    logic       span_load;  // set up span number span_sel
    logic [2:0] span_sel;   // 0..3 outline edges, 4 fill row
    logic       rd_px;      // issue read of current pixel's byte
    logic       wr_px;      // write modified byte, step pixel
    logic       rle_in;     // process an rle byte (phase update)
    logic       run_step;   // write one run byte
    logic       rle_end;    // report and reset load state
    logic       rd_addr;    // issue readback read
    logic       res_ok;     // present result
    logic       row_next;   // fill: next row
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic span_empty;   // set-up span has no pixel
    logic span_last;    // current pixel is last of span
    logic run_start;    // rle value byte starts a run
    logic run_last;
    logic rows_done;    // fill: row index past end
    logic rect_ok;      // w>0 && h>0
  } sts_t;

endpackage

>>> sv/gray4_bitplane_draw_engine_unit.sv
// Clear sweeps every byte of both planes; a pixel or line span reads, waits on and
// writes back each pixel's byte after set-up; an rle value byte writes its run.
// One word at a time: busy_o is high from acceptance to the result strobe.
// Result shows on the outputs for one cycle with done_o; receiver cannot stall.
// rst_ni asynchronous, active low: control and load state clear, then both
// planes are swept to zero with busy_o high.
module gray4_bitplane_draw_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         operation_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] rect_width_i,
  input  logic signed [15:0] rect_height_i,
  input  logic [1:0]         color_i,
  input  logic [7:0]         rle_byte_i,
  input  logic               plane_select_i,
  input  logic [11:0]        read_address_i,
  output logic               done_o,
  output logic               status_o,
  output logic [7:0]         read_high_o,
  output logic [7:0]         read_low_o
);
  g4bp_pkg::ctl_t ctl;
  g4bp_pkg::sts_t sts;

  g4bp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .operation_i, .sts_i(sts), .ctl_o(ctl), .busy_o
  );

  g4bp_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .operation_i, .x_i, .y_i, .rect_width_i, .rect_height_i, .color_i,
    .rle_byte_i, .plane_select_i, .read_address_i,
    .done_o, .status_o, .read_high_o, .read_low_o
  );
endmodule

>>> sv/g4bp_ram.sv
module g4bp_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/g4bp_datapath.sv
module g4bp_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  g4bp_pkg::ctl_t       ctl_i,
  output g4bp_pkg::sts_t       sts_o,
  input  logic [3:0]           operation_i,
  input  logic signed [15:0]   x_i,
  input  logic signed [15:0]   y_i,
  input  logic signed [15:0]   rect_width_i,
  input  logic signed [15:0]   rect_height_i,
  input  logic [1:0]           color_i,
  input  logic [7:0]           rle_byte_i,
  input  logic                 plane_select_i,
  input  logic [11:0]          read_address_i,
  output logic                 done_o,
  output logic                 status_o,
  output logic [7:0]           read_high_o,
  output logic [7:0]           read_low_o
);
  localparam int AW = g4bp_pkg::AddrW;

  logic [3:0]         op_q;
  logic signed [17:0] x_q, y_q, w_q, h_q;
  logic [1:0]         col_q;
  logic [7:0]         byte_q;
  logic               sel_q;
  logic [11:0]        raddr_q;

  // span walker: fixed coordinate, moving coordinate [lo,hi)
  logic               vert_q;
  logic signed [17:0] fix_q, cur_q, hi_q, row_q, rowhi_q;

  // rle load state
  logic [1:0]         phase_q;
  logic [15:0]        runc_q;
  logic [g4bp_pkg::FillW-1:0] filled_q;
  logic               lerr_q;
  logic [15:0]        runi_q;

  logic [AW:0]        clr_q;

  logic               status_q, rdv_q;
  logic [7:0]         rh_q, rl_q;
  logic               done_q;

  // span set-up arithmetic
  logic               sv;
  logic signed [17:0] sfix, sorg, slen, slo, shi, spix_x, spix_y;
  logic               on_panel;
  logic [AW-1:0]      px_addr;
  logic [7:0]         px_mask;

  always_comb begin
    sv   = 1'b0;
    sfix = y_q;
    sorg = x_q;
    slen = w_q;
    case (ctl_i.span_sel)
      3'd0: begin sv = 1'b0; sfix = y_q;           sorg = x_q; slen = w_q; end
      3'd1: begin sv = 1'b0; sfix = y_q + h_q - 18'sd1; sorg = x_q; slen = w_q; end
      3'd2: begin sv = 1'b1; sfix = x_q;           sorg = y_q; slen = h_q; end
      3'd3: begin sv = 1'b1; sfix = x_q + w_q - 18'sd1; sorg = y_q; slen = h_q; end
      default: begin sv = 1'b0; sfix = row_q;      sorg = x_q; slen = w_q; end
    endcase
    if (op_q == g4bp_pkg::OP_PIXEL) slen = 18'sd1;
    if (slen < 0) begin
      sorg = sorg + slen + 18'sd1;
      slen = -slen;
    end
    slo = (sorg < 0) ? 18'sd0 : sorg;
    shi = sorg + slen;
    if (sv) begin
      if (shi > g4bp_pkg::PanelHeight) shi = 18'(g4bp_pkg::PanelHeight);
    end else begin
      if (shi > g4bp_pkg::PanelWidth) shi = 18'(g4bp_pkg::PanelWidth);
    end
  end

  assign spix_x = vert_q ? fix_q : cur_q;
  assign spix_y = vert_q ? cur_q : fix_q;
  assign on_panel = (spix_x >= 0) && (spix_x < g4bp_pkg::PanelWidth) &&
                    (spix_y >= 0) && (spix_y < g4bp_pkg::PanelHeight);
  assign px_addr = AW'(spix_x[12:0] * 13'(g4bp_pkg::RowBytes) + 13'(spix_y[12:3]));
  assign px_mask = 8'h80 >> spix_y[2:0];

  // memories
  logic          we_h, we_l;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd_h, wd_l, rd_h, rd_l;
  logic [AW-1:0] pxa_q;
  logic          pxv_q;
  logic [AW:0]   runaddr;

  assign runaddr = (AW+1)'(filled_q) + (AW+1)'(runi_q);

  always_comb begin
    we_h = 1'b0;
    we_l = 1'b0;
    wa   = pxa_q;
    wd_h = col_q[1] ? (rd_h | px_mask) : (rd_h & ~px_mask);
    wd_l = col_q[0] ? (rd_l | px_mask) : (rd_l & ~px_mask);
    ra   = px_addr;
    if (ctl_i.rd_addr) ra = raddr_q;
    if (ctl_i.clr_step) begin
      we_h = 1'b1;
      we_l = 1'b1;
      wa   = clr_q[AW-1:0];
      wd_h = ctl_i.clr_zero ? 8'h00 : {8{col_q[1]}};
      wd_l = ctl_i.clr_zero ? 8'h00 : {8{col_q[0]}};
    end else if (ctl_i.wr_px) begin
      we_h = pxv_q;
      we_l = pxv_q;
    end else if (ctl_i.run_step) begin
      we_h = ~sel_q;
      we_l = sel_q;
      wa   = runaddr[AW-1:0];
      wd_h = byte_q;
      wd_l = byte_q;
    end
  end

  g4bp_ram #(.Width(8), .Depth(g4bp_pkg::FrameBytes)) u_high (
    .clk_i, .we_i(we_h), .waddr_i(wa), .wdata_i(wd_h), .raddr_i(ra), .rdata_o(rd_h)
  );
  g4bp_ram #(.Width(8), .Depth(g4bp_pkg::FrameBytes)) u_low (
    .clk_i, .we_i(we_l), .waddr_i(wa), .wdata_i(wd_l), .raddr_i(ra), .rdata_o(rd_l)
  );

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q    <= operation_i;
      x_q     <= 18'(x_i);
      y_q     <= 18'(y_i);
      w_q     <= 18'(rect_width_i);
      h_q     <= 18'(rect_height_i);
      col_q   <= color_i;
      byte_q  <= rle_byte_i;
      sel_q   <= plane_select_i;
      raddr_q <= read_address_i;
      row_q   <= (18'(y_i) < 0) ? 18'sd0 : 18'(y_i);
      rowhi_q <= (18'(y_i) + 18'(rect_height_i) > g4bp_pkg::PanelHeight) ?
                 18'(g4bp_pkg::PanelHeight) : 18'(y_i) + 18'(rect_height_i);
    end
    if (ctl_i.row_next) row_q <= row_q + 18'sd1;
    if (ctl_i.span_load) begin
      vert_q <= sv;
      fix_q  <= sfix;
      cur_q  <= slo;
      hi_q   <= shi;
    end
    if (ctl_i.rd_px) begin
      pxa_q <= px_addr;
      pxv_q <= on_panel;
    end
    if (ctl_i.wr_px) cur_q <= cur_q + 18'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      phase_q  <= '0;
      runc_q   <= '0;
      filled_q <= '0;
      lerr_q   <= 1'b0;
      runi_q   <= '0;
      status_q <= 1'b0;
      rdv_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= ctl_i.res_ok;
      if (ctl_i.latch) begin
        status_q <= 1'b0;
        rdv_q    <= 1'b0;
      end
      if (ctl_i.clr_init) clr_q <= '0;
      if (ctl_i.clr_step) clr_q <= clr_q + 1'b1;
      if (ctl_i.rle_in && !lerr_q) begin
        case (phase_q)
          2'd0: begin runc_q <= {byte_q, 8'h00}; phase_q <= 2'd1; end
          2'd1: begin runc_q[7:0] <= byte_q;     phase_q <= 2'd2; end
          default: begin
            phase_q <= 2'd0;
            runi_q  <= '0;
            if (!sts_o.run_start) lerr_q <= 1'b1;
          end
        endcase
      end
      if (ctl_i.run_step) begin
        runi_q <= runi_q + 16'd1;
        if (sts_o.run_last) begin
          filled_q <= filled_q + g4bp_pkg::FillW'(runc_q);
        end
      end
      if (ctl_i.rle_end) begin
        status_q <= lerr_q || (phase_q != 2'd0) ||
                    (filled_q != g4bp_pkg::FillW'(g4bp_pkg::FrameBytes));
        phase_q  <= '0;
        runc_q   <= '0;
        filled_q <= '0;
        lerr_q   <= 1'b0;
      end
      if (ctl_i.rd_addr) rdv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_ok) begin
      rh_q <= rdv_q ? rd_h : 8'h00;
      rl_q <= rdv_q ? rd_l : 8'h00;
    end
  end

  logic [16:0] run_end;
  assign run_end = 17'(filled_q) + 17'(runc_q);

  assign sts_o.clr_last   = (clr_q == (AW+1)'(g4bp_pkg::FrameBytes - 1));
  assign sts_o.span_empty = !(slo < shi);
  assign sts_o.span_last  = (cur_q + 18'sd1 >= hi_q);
  // value byte of a record with a legal count, load not in error
  assign sts_o.run_start  = (phase_q == 2'd2) && !lerr_q && (runc_q != 16'd0) &&
                            (run_end <= 17'(g4bp_pkg::FrameBytes));
  assign sts_o.run_last   = (runi_q + 16'd1 == runc_q);
  assign sts_o.rows_done  = !(row_q < rowhi_q);
  assign sts_o.rect_ok    = (w_q > 0) && (h_q > 0);

  assign done_o      = done_q;
  assign status_o    = done_q & status_q;
  assign read_high_o = done_q ? rh_q : 8'h00;
  assign read_low_o  = done_q ? rl_q : 8'h00;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.run_step |-> runaddr < (AW+1)'(g4bp_pkg::FrameBytes))
    else $error("run write past frame");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.clr_step, ctl_i.wr_px, ctl_i.run_step}))
    else $error("write sources collide");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result held over");
`endif
endmodule

>>> sv/g4bp_ctrl.sv
module g4bp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [3:0]     operation_i,
  input  g4bp_pkg::sts_t sts_i,
  output g4bp_pkg::ctl_t ctl_o,
  output logic           busy_o
);
  g4bp_pkg::state_e state_q, state_d;
  logic [3:0] op_q;
  logic [2:0] span_q, span_d;
  logic       byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= g4bp_pkg::ST_INIT;
      op_q    <= '0;
      span_q  <= '0;
      byte_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      span_q  <= span_d;
      if (state_q == g4bp_pkg::ST_IDLE && start_i) begin
        op_q   <= operation_i;
        byte_q <= 1'b1;
      end else begin
        byte_q <= 1'b0;
      end
    end
  end

  // span after the current one finishes
  logic [2:0] nxt_span;
  logic       more_span;
  always_comb begin
    nxt_span  = span_q;
    more_span = 1'b0;
    case (op_q)
      g4bp_pkg::OP_RECT: begin
        more_span = (span_q < 3'd3);
        nxt_span  = span_q + 3'd1;
      end
      g4bp_pkg::OP_FILL: begin
        more_span = 1'b1;
        nxt_span  = 3'd4;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    span_d  = span_q;
    ctl_o.span_sel = span_q;
    case (state_q)
      // zero both planes once after reset
      g4bp_pkg::ST_INIT: begin
        ctl_o.clr_step = 1'b1;
        ctl_o.clr_zero = 1'b1;
        if (sts_i.clr_last) state_d = g4bp_pkg::ST_IDLE;
      end
      g4bp_pkg::ST_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d = g4bp_pkg::ST_SPAN_SETUP;
          case (operation_i)
            g4bp_pkg::OP_CLEAR: begin
              ctl_o.clr_init = 1'b1;
              state_d = g4bp_pkg::ST_CLEAR;
            end
            g4bp_pkg::OP_PIXEL, g4bp_pkg::OP_HLINE: span_d = 3'd0;
            g4bp_pkg::OP_VLINE: span_d = 3'd2;
            g4bp_pkg::OP_RECT:  span_d = 3'd0;
            g4bp_pkg::OP_FILL:  span_d = 3'd4;
            g4bp_pkg::OP_RLEB:  state_d = g4bp_pkg::ST_RUN;
            g4bp_pkg::OP_READ:  state_d = g4bp_pkg::ST_READ_WAIT;
            default:            state_d = g4bp_pkg::ST_DONE;
          endcase
        end
      end
      g4bp_pkg::ST_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = g4bp_pkg::ST_DONE;
      end
      g4bp_pkg::ST_SPAN_SETUP: begin
        if ((op_q == g4bp_pkg::OP_RECT && !sts_i.rect_ok) ||
            (op_q == g4bp_pkg::OP_FILL && (!sts_i.rect_ok || sts_i.rows_done))) begin
          state_d = g4bp_pkg::ST_DONE;
        end else if (sts_i.span_empty) begin
          if (more_span && op_q == g4bp_pkg::OP_RECT) span_d = nxt_span;
          else if (op_q == g4bp_pkg::OP_FILL) ctl_o.row_next = 1'b1;
          else state_d = g4bp_pkg::ST_DONE;
        end else begin
          ctl_o.span_load = 1'b1;
          state_d = g4bp_pkg::ST_SPAN_RD;
        end
      end
      g4bp_pkg::ST_SPAN_RD: begin
        ctl_o.rd_px = 1'b1;
        state_d = g4bp_pkg::ST_SPAN_WAIT;
      end
      g4bp_pkg::ST_SPAN_WAIT: state_d = g4bp_pkg::ST_SPAN_WR;
      g4bp_pkg::ST_SPAN_WR: begin
        ctl_o.wr_px = 1'b1;
        if (!sts_i.span_last) begin
          state_d = g4bp_pkg::ST_SPAN_RD;
        end else if (op_q == g4bp_pkg::OP_FILL) begin
          ctl_o.row_next = 1'b1;
          state_d = g4bp_pkg::ST_SPAN_SETUP;
        end else if (more_span && op_q == g4bp_pkg::OP_RECT) begin
          span_d  = nxt_span;
          state_d = g4bp_pkg::ST_SPAN_SETUP;
        end else begin
          state_d = g4bp_pkg::ST_DONE;
        end
      end
      g4bp_pkg::ST_RUN: begin
        // first cycle: phase update; then one byte a cycle for a run
        if (byte_q) begin
          ctl_o.rle_in = 1'b1;
          if (!sts_i.run_start) state_d = g4bp_pkg::ST_DONE;
        end else begin
          ctl_o.run_step = 1'b1;
          if (sts_i.run_last) state_d = g4bp_pkg::ST_DONE;
        end
      end
      g4bp_pkg::ST_READ_WAIT: begin
        ctl_o.rd_addr = 1'b1;
        state_d = g4bp_pkg::ST_DONE;
      end
      g4bp_pkg::ST_DONE: begin
        if (op_q == g4bp_pkg::OP_RLEE && byte_q) ctl_o.rle_end = 1'b1;
        else begin
          ctl_o.res_ok = 1'b1;
          state_d = g4bp_pkg::ST_IDLE;
        end
      end
      default: state_d = g4bp_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != g4bp_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.latch |-> state_q == g4bp_pkg::ST_IDLE)
    else $error("latch while busy");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.wr_px |-> $past(ctl_o.rd_px, 2))
    else $error("write without read");
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_ok |=> state_q == g4bp_pkg::ST_IDLE)
    else $error("result not final");
`endif
endmodule

>>> test/gray4_bitplane_draw_engine_unit_chk.sv
module gray4_bitplane_draw_engine_unit_chk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [3:0]         operation_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] rect_width_i,
  input  logic signed [15:0] rect_height_i,
  input  logic [1:0]         color_i,
  input  logic [7:0]         rle_byte_i,
  input  logic               plane_select_i,
  input  logic [11:0]        read_address_i,
  input  logic               done_i,
  input  logic               status_i,
  input  logic [7:0]         read_high_i,
  input  logic [7:0]         read_low_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       status;
    logic [7:0] rd_high;
    logic [7:0] rd_low;
  } result_t;

  logic [7:0] shadow_high [g4bp_pkg::FrameBytes];
  logic [7:0] shadow_low  [g4bp_pkg::FrameBytes];
  int         rec_phase;
  int         run_len;
  int         filled;
  logic       load_err;
  result_t    expected_q [$];

  function automatic void px_put(int x, int y, logic [1:0] c);
    int   off;
    logic [7:0] mask;
    if (x < 0 || x >= g4bp_pkg::PanelWidth || y < 0 || y >= g4bp_pkg::PanelHeight) return;
    off = x * g4bp_pkg::RowBytes + y / 8;
    if (off >= g4bp_pkg::FrameBytes) return;
    mask = 8'h80 >> (y & 7);
    if (c[1]) shadow_high[off] |= mask;
    else shadow_high[off] &= ~mask;
    if (c[0]) shadow_low[off] |= mask;
    else shadow_low[off] &= ~mask;
  endfunction

  function automatic void span_h(int x, int y, int len, logic [1:0] c);
    int lo, hi;
    if (len < 0) begin
      x = x + len + 1;
      len = -len;
    end
    lo = (x < 0) ? 0 : x;
    hi = x + len;
    if (hi > g4bp_pkg::PanelWidth) hi = g4bp_pkg::PanelWidth;
    for (int i = lo; i < hi; i++) px_put(i, y, c);
  endfunction

  function automatic void span_v(int x, int y, int len, logic [1:0] c);
    int lo, hi;
    if (len < 0) begin
      y = y + len + 1;
      len = -len;
    end
    lo = (y < 0) ? 0 : y;
    hi = y + len;
    if (hi > g4bp_pkg::PanelHeight) hi = g4bp_pkg::PanelHeight;
    for (int i = lo; i < hi; i++) px_put(x, i, c);
  endfunction

  function automatic void rle_feed(logic [7:0] b, logic sel);
    if (load_err) return;
    if (rec_phase == 0) begin
      run_len = int'(b) << 8;
      rec_phase = 1;
    end else if (rec_phase == 1) begin
      run_len |= int'(b);
      rec_phase = 2;
    end else begin
      rec_phase = 0;
      if (run_len == 0 || filled + run_len > g4bp_pkg::FrameBytes) begin
        load_err = 1'b1;
        return;
      end
      for (int i = 0; i < run_len; i++) begin
        if (sel) shadow_low[filled + i] = b;
        else shadow_high[filled + i] = b;
      end
      filled += run_len;
    end
  endfunction

  function automatic result_t predict_word();
    result_t r;
    int x, y, w, h, lo, hi;
    r = '0;
    x = int'(x_i);
    y = int'(y_i);
    w = int'(rect_width_i);
    h = int'(rect_height_i);
    case (operation_i)
      g4bp_pkg::OP_CLEAR: begin
        for (int i = 0; i < g4bp_pkg::FrameBytes; i++) begin
          shadow_high[i] = {8{color_i[1]}};
          shadow_low[i]  = {8{color_i[0]}};
        end
      end
      g4bp_pkg::OP_PIXEL: px_put(x, y, color_i);
      g4bp_pkg::OP_HLINE: span_h(x, y, w, color_i);
      g4bp_pkg::OP_VLINE: span_v(x, y, h, color_i);
      g4bp_pkg::OP_RECT: begin
        if (w > 0 && h > 0) begin
          span_h(x, y, w, color_i);
          span_h(x, y + h - 1, w, color_i);
          span_v(x, y, h, color_i);
          span_v(x + w - 1, y, h, color_i);
        end
      end
      g4bp_pkg::OP_FILL: begin
        if (w > 0 && h > 0) begin
          lo = (y < 0) ? 0 : y;
          hi = y + h;
          if (hi > g4bp_pkg::PanelHeight) hi = g4bp_pkg::PanelHeight;
          for (int rw = lo; rw < hi; rw++) span_h(x, rw, w, color_i);
        end
      end
      g4bp_pkg::OP_RLEB: rle_feed(rle_byte_i, plane_select_i);
      g4bp_pkg::OP_RLEE: begin
        r.status = load_err || rec_phase != 0 || filled != g4bp_pkg::FrameBytes;
        rec_phase = 0;
        run_len = 0;
        filled = 0;
        load_err = 1'b0;
      end
      g4bp_pkg::OP_READ: begin
        r.rd_high = shadow_high[read_address_i];
        r.rd_low  = shadow_low[read_address_i];
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    int      errs;
    errs = 0;
    if (!rst_ni) begin
      rec_phase = 0;
      run_len = 0;
      filled = 0;
      load_err = 1'b0;
      for (int i = 0; i < g4bp_pkg::FrameBytes; i++) begin
        shadow_high[i] = 8'h00;
        shadow_low[i]  = 8'h00;
      end
      fail_count_o <= 0;
    end else begin
      // result of the older word is settled before the next word is taken
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no word outstanding");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (status_i !== e.status) begin
            $error("status: expected %0h, got %0h", e.status, status_i);
            errs++;
          end
          if (read_high_i !== e.rd_high) begin
            $error("read_high: expected %0h, got %0h", e.rd_high, read_high_i);
            errs++;
          end
          if (read_low_i !== e.rd_low) begin
            $error("read_low: expected %0h, got %0h", e.rd_low, read_low_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (start_i && !busy_i) expected_q.push_back(predict_word());
    end
  end

endmodule

>>> test/gray4_bitplane_draw_engine_unit_tb.sv
module gray4_bitplane_draw_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [3:0]         operation_i = g4bp_pkg::OP_READ;
  logic signed [15:0] x_i = '0;
  logic signed [15:0] y_i = '0;
  logic signed [15:0] rect_width_i = '0;
  logic signed [15:0] rect_height_i = '0;
  logic [1:0]         color_i = '0;
  logic [7:0]         rle_byte_i = '0;
  logic               plane_select_i = 1'b0;
  logic [11:0]        read_address_i = '0;
  logic               done_o, status_o;
  logic [7:0]         read_high_o, read_low_o;
  int                 fail_count, pending;
  int                 words_sent;
  bit                 no_gaps;

  always #5 clk_i = ~clk_i;

  gray4_bitplane_draw_engine_unit uut (.*);

  gray4_bitplane_draw_engine_unit_chk chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .x_i, .y_i,
    .rect_width_i, .rect_height_i, .color_i, .rle_byte_i, .plane_select_i,
    .read_address_i, .done_i(done_o), .status_i(status_o),
    .read_high_i(read_high_o), .read_low_i(read_low_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // hands one word over; fields not given are random
  task automatic send(logic [3:0] op, int x = $urandom, int y = $urandom,
                      int w = $urandom, int h = $urandom,
                      logic [1:0] c = 2'($urandom), logic [7:0] b = 8'($urandom),
                      logic sel = 1'($urandom), logic [11:0] addr = 12'($urandom));
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    x_i <= x[15:0];
    y_i <= y[15:0];
    rect_width_i <= w[15:0];
    rect_height_i <= h[15:0];
    color_i <= c;
    rle_byte_i <= b;
    plane_select_i <= sel;
    read_address_i <= addr;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    words_sent++;
  endtask

  task automatic rle_rec(int cnt, logic [7:0] val);
    send(g4bp_pkg::OP_RLEB, .b(cnt[15:8]));
    send(g4bp_pkg::OP_RLEB, .b(cnt[7:0]));
    send(g4bp_pkg::OP_RLEB, .b(val));
  endtask

  // full-frame stream; flaw 0 well formed, 1 zero count, 2 overflow,
  // 3 cut mid record, 4 short frame, 5 trailing bytes after a full frame
  task automatic rle_stream(int flaw);
    int left, nrec, cnt;
    left = g4bp_pkg::FrameBytes;
    nrec = $urandom_range(1, 10);
    for (int r = 0; r < nrec; r++) begin
      cnt = (r == nrec - 1) ? left : $urandom_range(1, left - (nrec - 1 - r));
      if (flaw == 1 && r == nrec - 1) cnt = 0;
      if (flaw == 2 && r == nrec - 1) cnt = left + $urandom_range(1, 300);
      if (flaw == 4 && r == nrec - 1 && cnt > 1) cnt = cnt - 1;
      if (flaw == 3 && r == nrec - 1) begin
        send(g4bp_pkg::OP_RLEB, .b(cnt[15:8]));
        if ($urandom_range(0, 1)) send(g4bp_pkg::OP_RLEB, .b(cnt[7:0]));
      end else begin
        rle_rec(cnt, 8'($urandom));
      end
      left -= cnt;
    end
    if (flaw == 5 || flaw == 1) repeat ($urandom_range(1, 5)) send(g4bp_pkg::OP_RLEB);
    send(g4bp_pkg::OP_RLEE);
    repeat ($urandom_range(2, 8)) send(g4bp_pkg::OP_READ);
  endtask

  task automatic draw_random();
    int k;
    int x, y, w, h;
    k = $urandom_range(0, 99);
    x = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 271) - 8;
    y = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 143) - 8;
    w = $urandom_range(0, 40) - 20;
    h = $urandom_range(0, 40) - 20;
    if (k < 30) send(g4bp_pkg::OP_READ);
    else if (k < 45) send(g4bp_pkg::OP_PIXEL, x, y);
    else if (k < 58) send(g4bp_pkg::OP_HLINE, x, y,
                          ($urandom_range(0, 9) == 0) ? $urandom : w);
    else if (k < 70) send(g4bp_pkg::OP_VLINE, x, y, $urandom,
                          ($urandom_range(0, 9) == 0) ? $urandom : h);
    else if (k < 82) send(g4bp_pkg::OP_RECT, x, y,
                          ($urandom_range(0, 19) == 0) ? $urandom : w,
                          ($urandom_range(0, 19) == 0) ? $urandom : h);
    else if (k < 94) send(g4bp_pkg::OP_FILL, x, y, w, h);
    else if (k < 95) send(g4bp_pkg::OP_CLEAR);
    else if (k < 97) send(4'($urandom_range(int'(g4bp_pkg::OP_READ) + 1, 15)));
    else if (k < 98) send(g4bp_pkg::OP_RLEE);
    else send(g4bp_pkg::OP_RLEB);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // planes come out of reset zeroed
    send(g4bp_pkg::OP_READ, .addr(12'd0));
    send(g4bp_pkg::OP_READ, .addr(12'd2047));
    send(g4bp_pkg::OP_CLEAR, .c(2'd0));
    send(g4bp_pkg::OP_READ, .addr(12'd0));
    send(g4bp_pkg::OP_PIXEL, 0, 0, .c(2'd3));
    send(g4bp_pkg::OP_PIXEL, g4bp_pkg::PanelWidth - 1, g4bp_pkg::PanelHeight - 1,
         .c(2'd2));
    send(g4bp_pkg::OP_PIXEL, -32768, 32767, .c(2'd1));
    send(g4bp_pkg::OP_PIXEL, 32767, -32768, .c(2'd3));
    send(g4bp_pkg::OP_READ, .addr(12'd0));
    send(g4bp_pkg::OP_READ, .addr(12'hFFF));
    send(g4bp_pkg::OP_HLINE, 10, 5, -7, .c(2'd3));
    send(g4bp_pkg::OP_HLINE, -3, 127, 32767, .c(2'd1));
    send(g4bp_pkg::OP_VLINE, 20, 10, 0, -12, 2'd2);
    send(g4bp_pkg::OP_VLINE, 255, -100, 0, -32768, 2'd3);
    send(g4bp_pkg::OP_RECT, 30, 30, 5, 4, 2'd3);
    send(g4bp_pkg::OP_RECT, 30, 30, 0, 4, 2'd1);
    send(g4bp_pkg::OP_RECT, 30, 30, 4, -1, 2'd1);
    send(g4bp_pkg::OP_FILL, -32768, -32768, 32767, 32767, 2'd2);
    send(g4bp_pkg::OP_FILL, 40, 40, -5, 3, 2'd0);
    send(g4bp_pkg::OP_READ, .addr(12'd640));
    send(4'(int'(g4bp_pkg::OP_READ) + 1));
    send(4'hF);
    send(g4bp_pkg::OP_CLEAR, .c(2'd3));
    rle_stream(0);
    rle_stream(1);
    rle_stream(2);
    rle_stream(3);
    rle_stream(4);
    send(g4bp_pkg::OP_CLEAR, .c(2'd1));
    while (words_sent < 1450) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0)
        rle_stream(($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
      else
        repeat ($urandom_range(10, 40)) draw_random();
      if (words_sent > 700 && words_sent < 760) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
    end
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (5000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
sv/g4bp_pkg.sv
sv/g4bp_ram.sv
sv/g4bp_datapath.sv
sv/g4bp_ctrl.sv
sv/gray4_bitplane_draw_engine_unit.sv
test/gray4_bitplane_draw_engine_unit_chk.sv
test/gray4_bitplane_draw_engine_unit_tb.sv
